// ===== src/swe_pkg.sv =====
// package for the sliding window extreme block
// holds item types, register codes and the cell control group
// no dependencies
`default_nettype none

package swe_pkg;

	localparam int DATA_W     = 32;
	localparam int CFG_DATA_W = 7;
	localparam int CFG_IDX_W  = 1;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SELECT_MIN    = 1'd1;

	typedef struct packed {
		logic signed [DATA_W-1:0] sample;
		logic                     first_of_stream;
	} swe_in_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] extreme_value;
		logic                     window_full;
	} swe_out_t;

	// broadcast control for the cell row
	typedef struct packed {
		logic shift;
		logic first;
		logic select_min;
	} swe_cell_ctl_t;

endpackage

`default_nettype wire

// ===== src/swe_cell.sv =====
// one cell of the candidate row: holds one past sample and its live flag
// uses swe_pkg for the data width and the control group
`default_nettype none

module swe_cell import swe_pkg::*; (
	input  wire                      clk,
	input  wire                      arst_n,
	input  swe_cell_ctl_t            ctl,
	input  wire signed [DATA_W-1:0]  sample,
	input  wire                      expired,
	input  wire signed [DATA_W-1:0]  prev_value,
	input  wire                      prev_alive,
	input  wire                      stop_in,
	output logic signed [DATA_W-1:0] value,
	output logic                     alive,
	output logic                     stop_out
);

	logic live;
	logic dominated;
	logic keep;

	assign live      = prev_alive & ~ctl.first & ~expired;
	assign dominated = ctl.select_min ? (sample < prev_value) : (sample > prev_value);
	// removal from the back stops at the newest live entry that holds
	assign keep      = live & (stop_in | ~dominated);
	assign stop_out  = stop_in | (live & ~dominated);

	logic signed [DATA_W-1:0] value_q;
	logic                     alive_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alive_q <= 1'b0;
		end else if (ctl.shift) begin
			alive_q <= keep;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			value_q <= prev_value;
		end
	end

	assign value = value_q;
	assign alive = alive_q;

endmodule

`default_nettype wire

// ===== src/swe_front.sv =====
// two stage select tree: finds the oldest live entry of the cell row
// uses swe_pkg for the data width
`default_nettype none

module swe_front import swe_pkg::*; #(
	parameter int N = 64
) (
	input  wire                      clk,
	input  wire                      load,
	input  wire  [N-1:0]             alive,
	input  wire signed [DATA_W-1:0]  data [N],
	output logic signed [DATA_W-1:0] root_data
);

	localparam int L  = $clog2(N);
	localparam int P  = 1 << L;
	localparam int L1 = (L + 1) / 2;
	localparam int M  = P >> L1;

	logic                     mid_alive [M];
	logic signed [DATA_W-1:0] mid_data  [M];
	logic                     mid_alive_s2 [M];
	logic signed [DATA_W-1:0] mid_data_s2  [M];

	// lower levels, higher index is older and wins
	always_comb begin
		logic                     av [P];
		logic signed [DATA_W-1:0] dv [P];
		for (int j = 0; j < P; j++) begin
			if (j < N) begin
				av[j] = alive[j];
				dv[j] = data[j];
			end else begin
				av[j] = 1'b0;
				dv[j] = '0;
			end
		end
		for (int k = 0; k < L1; k++) begin
			for (int j = 0; j < P / 2; j++) begin
				if (j < (P >> (k + 1))) begin
					dv[j] = av[2*j+1] ? dv[2*j+1] : dv[2*j];
					av[j] = av[2*j+1] | av[2*j];
				end
			end
		end
		for (int j = 0; j < M; j++) begin
			mid_alive[j] = av[j];
			mid_data[j]  = dv[j];
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			mid_alive_s2 <= mid_alive;
			mid_data_s2  <= mid_data;
		end
	end

	// upper levels
	always_comb begin
		logic                     bv [M];
		logic signed [DATA_W-1:0] bd [M];
		for (int j = 0; j < M; j++) begin
			bv[j] = mid_alive_s2[j];
			bd[j] = mid_data_s2[j];
		end
		for (int k = 0; k < L - L1; k++) begin
			for (int j = 0; j < M / 2; j++) begin
				if (j < (M >> (k + 1))) begin
					bd[j] = bv[2*j+1] ? bd[2*j+1] : bd[2*j];
					bv[j] = bv[2*j+1] | bv[2*j];
				end
			end
		end
		root_data = bd[0];
	end

endmodule

`default_nettype wire

// ===== src/sliding_window_extreme_core.sv =====
// top level of the sliding window maximum / minimum block
// uses swe_pkg, swe_cell and swe_front
`default_nettype none

//  channel   handshake                    payload             direction
//  item      item_valid / item_ready      swe_in_t item_data  into the block
//  result    result_valid / result_ready  swe_out_t           out of the block
//  config    cfg_write                    cfg_index, cfg_data into the block
//
//  the accepting edge updates the cell row, the tree state registers the lower
//  half of the select tree and the root state loads the output register once it
//  is free; the sequencer returns to idle on that load, so a new item is taken
//  only after the last one has reached the output register
//  reset clears every cell live flag, the sample count and the control state;
//  window length resets to 1 and the block tracks the maximum
//  a result waits in the output register while the next item is accepted;
//  that item then holds in the tree root stage until the register is free

module sliding_window_extreme_core import swe_pkg::*; #(
	parameter int WINDOW_MAX = 64
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   item_valid,
	output logic                  item_ready,
	input  swe_in_t               item_data,
	output logic                  result_valid,
	input  wire                   result_ready,
	output swe_out_t              result_data,
	input  wire                   cfg_write,
	input  wire  [CFG_IDX_W-1:0]  cfg_index,
	input  wire  [CFG_DATA_W-1:0] cfg_data
);

	// widths of the sample count and of length compares
	localparam int LW   = $clog2(WINDOW_MAX + 1);
	localparam int CMPW = (LW > CFG_DATA_W) ? LW : CFG_DATA_W;

	// sequencer codes
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_TREE = 2'd1;
	localparam logic [1:0] ST_ROOT = 2'd2;

	logic [1:0] state_q;

	// configuration registers
	logic [CFG_DATA_W-1:0] win_len_q;
	logic                  sel_min_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_len_q <= CFG_DATA_W'(1);
			sel_min_q <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_WINDOW_LENGTH: win_len_q <= cfg_data;
				REG_SELECT_MIN:    sel_min_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// length clamped to 1 .. WINDOW_MAX
	logic [CMPW-1:0] wl_ext;
	logic [CMPW-1:0] len_eff;

	assign wl_ext  = CMPW'(win_len_q);
	assign len_eff = (wl_ext == '0) ? CMPW'(1) :
	                 (wl_ext > CMPW'(WINDOW_MAX)) ? CMPW'(WINDOW_MAX) : wl_ext;

	logic accept;

	assign item_ready = (state_q == ST_IDLE);
	assign accept     = item_valid & item_ready;

	// cell row: position i holds the sample of age i after the update,
	// position 0 is the head register that takes the new sample
	logic                     alive_v [WINDOW_MAX];
	logic signed [DATA_W-1:0] data_v  [WINDOW_MAX];
	logic [WINDOW_MAX-1:0]    alive_bits;
	logic [WINDOW_MAX-1:0]    expired_v;
	logic [WINDOW_MAX:1]      stop_v;

	logic signed [DATA_W-1:0] head_val_q;
	logic                     head_alive_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_alive_q <= 1'b0;
		end else if (accept) begin
			head_alive_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			head_val_q <= item_data.sample;
		end
	end

	assign alive_v[0] = head_alive_q;
	assign data_v[0]  = head_val_q;

	swe_cell_ctl_t cell_ctl;

	assign cell_ctl.shift      = accept;
	assign cell_ctl.first      = item_data.first_of_stream;
	assign cell_ctl.select_min = sel_min_q;

	// back removal starts at the newest old entry
	assign stop_v[1] = 1'b0;

	genvar gi;
	generate
		for (gi = 0; gi < WINDOW_MAX; gi++) begin : g_exp
			// the entry landing here is past the window
			assign expired_v[gi]  = (CMPW'(gi) >= len_eff);
			assign alive_bits[gi] = alive_v[gi];
		end
		for (gi = 1; gi < WINDOW_MAX; gi++) begin : g_cell
			swe_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctl        (cell_ctl),
				.sample     (item_data.sample),
				.expired    (expired_v[gi]),
				.prev_value (data_v[gi-1]),
				.prev_alive (alive_v[gi-1]),
				.stop_in    (stop_v[gi]),
				.value      (data_v[gi]),
				.alive      (alive_v[gi]),
				.stop_out   (stop_v[gi+1])
			);
		end
	endgenerate

	// samples seen since stream start, saturating
	logic [LW-1:0] seen_q;
	logic [LW-1:0] seen_next;

	always_comb begin
		if (item_data.first_of_stream) begin
			seen_next = LW'(1);
		end else if (seen_q == LW'(WINDOW_MAX)) begin
			seen_next = seen_q;
		end else begin
			seen_next = seen_q + LW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (accept) begin
			seen_q <= seen_next;
		end
	end

	logic full_s1;
	logic full_s2;

	always_ff @(posedge clk) begin
		if (accept) begin
			full_s1 <= (CMPW'(seen_next) >= len_eff);
		end
		if (state_q == ST_TREE) begin
			full_s2 <= full_s1;
		end
	end

	// front of the deque: oldest live entry
	logic signed [DATA_W-1:0] root_data;

	swe_front #(
		.N (WINDOW_MAX)
	) u_front (
		.clk       (clk),
		.load      (state_q == ST_TREE),
		.alive     (alive_bits),
		.data      (data_v),
		.root_data (root_data)
	);

	// output register
	logic     res_valid_q;
	swe_out_t result_q;
	logic     load_out;

	assign load_out = (state_q == ST_ROOT) & (~res_valid_q | result_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_out) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			result_q.extreme_value <= full_s2 ? root_data : '0;
			result_q.window_full   <= full_s2;
		end
	end

	assign result_valid = res_valid_q;
	assign result_data  = result_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) state_q <= ST_TREE;
				end
				ST_TREE: begin
					state_q <= ST_ROOT;
				end
				ST_ROOT: begin
					if (load_out) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// no old entry held against the new sample: the new sample is the only one live
	a_all_removed: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !stop_v[WINDOW_MAX] |=> (alive_bits[WINDOW_MAX-1:1] == '0))
		else $error("dominated entries left live");

	// no live entry outside the window after an update
	a_no_stale: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> ((alive_bits & expired_v) == '0))
		else $error("expired entry still live");

	// start of stream leaves only the new sample live
	a_first_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item_data.first_of_stream |=> ($countones(alive_bits) == 1))
		else $error("stream start did not clear the row");

	// a result only appears from the root stage
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> ($past(state_q) == ST_ROOT))
		else $error("result without a finished item");

endmodule

`default_nettype wire
